@@ rtl/vefd_pkg.sv @@
package vefd_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_FIELD_SIZE_SEL = 2'd0;
   localparam logic [1:0] CSR_ENCODING_MODE  = 2'd1;
   localparam logic [1:0] CSR_SIGNED_RESULT  = 2'd2;

   // Encoding modes. The remaining code decodes as little endian.
   localparam logic [1:0] ENC_LITTLE = 2'd0;
   localparam logic [1:0] ENC_BIG    = 2'd1;
   localparam logic [1:0] ENC_VARINT = 2'd2;

   // Field sizes.
   localparam logic [1:0] SIZE_1B = 2'd0;
   localparam logic [1:0] SIZE_2B = 2'd1;
   localparam logic [1:0] SIZE_4B = 2'd2;
   localparam logic [1:0] SIZE_8B = 2'd3;

   localparam logic [1:0] FIELD_SIZE_SEL_RESET = SIZE_4B;

   // Varint length limits for 2 and 4 byte fields.
   localparam int VARINT_LIMIT_16 = 3;
   localparam int VARINT_LIMIT_32 = 5;

   // Accumulator positions are meaningful only below these counts.
   localparam logic [3:0] VARINT_GROUPS = 4'd10;
   localparam logic [3:0] FIXED_BYTES   = 4'd8;

   localparam logic [7:0] CONT_BIT = 8'h80;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TRUNC    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // One classified byte, as handed from the front to the back.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] size_sel;
      logic       varint;
      logic       big;
      logic       sgn;
      logic [3:0] limit;
   } item_type;

   function automatic logic [63:0] width_mask(input logic [1:0] size_sel);
      logic [63:0] m;
      case (size_sel)
         SIZE_1B: m = 64'h0000_0000_0000_00ff;
         SIZE_2B: m = 64'h0000_0000_0000_ffff;
         SIZE_4B: m = 64'h0000_0000_ffff_ffff;
         default: m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [63:0] sign_ext(input logic [63:0] v,
                                            input logic [1:0] size_sel);
      logic [63:0] r;
      case (size_sel)
         SIZE_1B: r = {{56{v[7]}}, v[7:0]};
         SIZE_2B: r = {{48{v[15]}}, v[15:0]};
         SIZE_4B: r = {{32{v[31]}}, v[31:0]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/vefd_front.sv @@
module vefd_front
   import vefd_pkg::*;
#(
   parameter int MAX_VARINT_BYTES = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   localparam logic [3:0] LIMIT_16 = 4'(VARINT_LIMIT_16);
   localparam logic [3:0] LIMIT_32 = 4'((MAX_VARINT_BYTES < VARINT_LIMIT_32) ?
                                        MAX_VARINT_BYTES : VARINT_LIMIT_32);
   localparam logic [3:0] LIMIT_64 = 4'(MAX_VARINT_BYTES);

   logic [1:0] size_sel_ff, size_sel_in;
   logic [1:0] mode_ff, mode_in;
   logic       sgn_ff, sgn_in;

   assign csr_ready = 1'b1;

   always_comb begin
      size_sel_in = size_sel_ff;
      mode_in     = mode_ff;
      sgn_in      = sgn_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIELD_SIZE_SEL: size_sel_in = csr_wdata[1:0];
            CSR_ENCODING_MODE:  mode_in     = csr_wdata[1:0];
            CSR_SIGNED_RESULT:  sgn_in      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_sel_ff <= FIELD_SIZE_SEL_RESET;
         mode_ff     <= ENC_LITTLE;
         sgn_ff      <= 1'b0;
      end else begin
         size_sel_ff <= size_sel_in;
         mode_ff     <= mode_in;
         sgn_ff      <= sgn_in;
      end
   end

   // Each byte carries the settings it was accepted under.
   always_comb begin
      q_item.data     = req_tdata;
      q_item.last     = req_tlast;
      q_item.size_sel = size_sel_ff;
      q_item.varint   = (mode_ff == ENC_VARINT) && (size_sel_ff != SIZE_1B);
      q_item.big      = (mode_ff == ENC_BIG);
      q_item.sgn      = sgn_ff;
      unique case (size_sel_ff)
         SIZE_2B: q_item.limit = LIMIT_16;
         SIZE_4B: q_item.limit = LIMIT_32;
         default: q_item.limit = LIMIT_64;
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

@@ rtl/vefd_queue.sv @@
module vefd_queue
   import vefd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == DEPTH_CNT);
   assign valid    = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/vefd_back.sv @@
module vefd_back
   import vefd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   output logic [1:0]  rsp_tuser
);

   logic [63:0] acc_ff, acc_in;
   logic [3:0]  count_ff, count_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_value_ff, out_value_in;
   status_type  out_status_ff, out_status_in;
   logic [3:0]  out_bytes_ff, out_bytes_in;

   logic        fire;
   logic [3:0]  cnt;
   logic [3:0]  size_bytes;
   logic [5:0]  vshift;
   logic [5:0]  fshift;
   logic [63:0] acc_new;
   logic [63:0] raw;
   logic [63:0] zz;
   logic [63:0] value;
   logic        done;
   status_type  status;

   assign fire  = q_valid && (!out_valid_ff || rsp_tready);
   assign q_pop = fire;

   assign cnt        = count_ff + 4'd1;
   assign size_bytes = 4'd1 << q_item.size_sel;
   // Seven payload bits per varint byte.
   assign vshift     = 6'({count_ff, 3'b000} - {3'b000, count_ff});
   assign fshift     = {count_ff[2:0], 3'b000};

   always_comb begin
      acc_new = acc_ff;
      if (q_item.varint) begin
         if (count_ff < VARINT_GROUPS) begin
            acc_new = acc_ff | (64'(q_item.data[6:0]) << vshift);
         end
      end else if (q_item.big) begin
         acc_new = {acc_ff[55:0], q_item.data};
      end else if (count_ff < FIXED_BYTES) begin
         acc_new = acc_ff | (64'(q_item.data) << fshift);
      end
   end

   always_comb begin
      raw = acc_new & width_mask(q_item.size_sel);
      zz  = ({1'b0, raw[63:1]} ^ {64{raw[0]}}) & width_mask(q_item.size_sel);
      if (!q_item.sgn) begin
         value = raw;
      end else if (q_item.varint) begin
         value = sign_ext(zz, q_item.size_sel);
      end else begin
         value = sign_ext(raw, q_item.size_sel);
      end
   end

   always_comb begin
      done   = 1'b0;
      status = STATUS_OK;
      if (q_item.varint) begin
         if ((q_item.data & CONT_BIT) == 8'h00) begin
            done = 1'b1;
         end else if (cnt >= q_item.limit) begin
            done   = 1'b1;
            status = STATUS_OVERFLOW;
         end else if (q_item.last) begin
            done   = 1'b1;
            status = STATUS_TRUNC;
         end
      end else if (cnt >= size_bytes) begin
         done = 1'b1;
      end else if (q_item.last) begin
         done   = 1'b1;
         status = STATUS_TRUNC;
      end
   end

   always_comb begin
      acc_in        = acc_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_bytes_in  = out_bytes_ff;
      if (fire) begin
         acc_in   = done ? 64'd0 : acc_new;
         count_in = done ? 4'd0 : cnt;
         if (done) begin
            out_valid_in  = 1'b1;
            out_value_in  = (status == STATUS_OK) ? value : 64'd0;
            out_status_in = status;
            out_bytes_in  = cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_bytes_ff  <= out_bytes_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_bytes_ff, out_value_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

@@ rtl/varint_endian_field_decoder.sv @@
// Channel   Direction  Word contents (lowest bit first)
// req_      in         tdata[7:0] data_byte; tlast buffer_end
// rsp_      out        tdata[63:0] value, [67:64] field_bytes; tuser[1:0] status
// csr_      in         csr_index register index, csr_wdata[7:0] value
//
// One byte is taken per cycle while the queue is not full; results are registered.
// The per-byte accumulate and finish step in the back end sets this rate.
// Synchronous active-high reset restores the register defaults and empties the queue.
// A stalled result port holds one result; the two-entry queue then fills
// and req_tready drops until the result is taken.
module varint_endian_field_decoder
   import vefd_pkg::*;
#(
   parameter int MAX_VARINT_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] value, [67:64] field_bytes
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic     q_full;
   logic     q_push;
   item_type q_in;
   logic     q_valid;
   logic     q_pop;
   item_type q_out;

   vefd_front #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in)
   );

   vefd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_out)
   );

   vefd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/vefd_checker.sv @@
module vefd_checker
   import vefd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A result waiting at the port keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // Errors always carry a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[63:0] == 64'd0)
      else $error("error result with nonzero value");

   // A field consumes between one and ten bytes.
   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:64] != 4'd0 && rsp_tdata[67:64] <= 4'd10)
      else $error("field byte count out of range");

   // An overflow needs at least a three-byte varint.
   a_ovf_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OVERFLOW |-> rsp_tdata[67:64] >= 4'd3)
      else $error("overflow reported on a short varint");

   // No result is shown right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind varint_endian_field_decoder vefd_checker u_vefd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ verif/varint_endian_field_decoder_tb.sv @@
`timescale 1ns / 100ps

module varint_endian_field_decoder_tb;
   import vefd_pkg::*;

   localparam int MAX_VARINT_BYTES = 10;
   localparam int VARINT_LIMIT_64  = MAX_VARINT_BYTES;
   localparam int ITEM_TARGET      = 2000;
   localparam int STALL_CYCLES     = 300;
   localparam int DRAIN_CYCLES     = 6;
   localparam int REPORT_LIMIT     = 10;

   // The unused encoding code falls back to little endian.
   localparam logic [1:0] ENC_AS_LITTLE = 2'd3;

   typedef struct packed {
      logic [63:0] value;
      status_type  status;
      logic [3:0]  nbytes;
   } field_result_type;

   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [1:0]       index;
      logic [7:0]       data;
      logic             last;
      logic             typed;
      field_result_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   varint_endian_field_decoder #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow copy of the decoder configuration and field state.
   logic [1:0]  dec_size_sel = FIELD_SIZE_SEL_RESET;
   logic [1:0]  dec_enc = ENC_LITTLE;
   logic        dec_sgn = 1'b0;
   logic [63:0] dec_acc = '0;
   logic [3:0]  dec_pos = '0;

   field_result_type pending_fields[$];
   int mismatches = 0;
   int items_sent = 0;
   int send_idle_pct = 17;
   int recv_idle_pct = 64;
   bit stall_req = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Consumes one byte of the stream; returns 1 when it closes a field.
   function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                      output field_result_type r);
      int unsigned size, w, limit;
      int          pos, cnt;
      logic [63:0] mask, u;
      bit          varint, done;
      status_type  st;
      size   = 1 << dec_size_sel;
      w      = 8 * size;
      mask   = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      varint = (dec_enc == ENC_VARINT) && (size > 1);
      pos    = dec_pos;
      cnt    = pos + 1;
      st     = STATUS_OK;
      done   = 1'b0;
      u      = '0;
      if (varint) begin
         limit = (size == 2) ? VARINT_LIMIT_16 : (size == 4) ? VARINT_LIMIT_32
                                                             : VARINT_LIMIT_64;
         if (limit > MAX_VARINT_BYTES)
            limit = MAX_VARINT_BYTES;
         if (pos < VARINT_GROUPS)
            dec_acc |= 64'(b[6:0]) << (7 * pos);
         if (!b[7]) begin
            u = dec_acc & mask;
            if (dec_sgn) begin
               u = ((u >> 1) ^ (64'd0 - {63'd0, u[0]})) & mask;
               if (w < 64 && u[w-1])
                  u |= ~mask;
            end
            done = 1'b1;
         end else if (cnt >= limit) begin
            st   = STATUS_OVERFLOW;
            done = 1'b1;
         end else if (last) begin
            st   = STATUS_TRUNC;
            done = 1'b1;
         end
      end else begin
         if (dec_enc == ENC_BIG)
            dec_acc = {dec_acc[55:0], b};
         else if (pos < FIXED_BYTES)
            dec_acc |= 64'(b) << (8 * pos);
         if (cnt >= size) begin
            u = dec_acc & mask;
            if (dec_sgn && w < 64 && u[w-1])
               u |= ~mask;
            done = 1'b1;
         end else if (last) begin
            st   = STATUS_TRUNC;
            done = 1'b1;
         end
      end
      r = '0;
      if (!done) begin
         dec_pos = 4'(cnt);
         return 1'b0;
      end
      r.value  = (st == STATUS_OK) ? u : 64'd0;
      r.status = st;
      r.nbytes = 4'(cnt);
      dec_acc  = '0;
      dec_pos  = '0;
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input field_result_type want,
                                input field_result_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t %s: value %h/%h status %0d/%0d bytes %0d/%0d (expected/actual)",
                  $time, what, want.value, got.value, want.status, got.status,
                  want.nbytes, got.nbytes);
   endtask

   always @(posedge clock) begin
      field_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value  = rsp_tdata[63:0];
         got.nbytes = rsp_tdata[67:64];
         got.status = status_type'(rsp_tuser);
         if (pending_fields.size() == 0) begin
            flag_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_fields.pop_front();
            if (got.value !== want.value || got.status !== want.status ||
                got.nbytes !== want.nbytes)
               flag_mismatch("result mismatch", want, got);
         end
      end
   end

   // Result side: random back-pressure plus an optional long hold-off.
   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_req) begin
            stall_req = 0;
            hold = STALL_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                            input field_result_type want);
      field_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (decode_byte(b, last, r))
         pending_fields.push_back(typed ? want : r);
      items_sent++;
   endtask

   // Register writes wait until every expected result has been received.
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      req_tvalid <= 1'b0;
      while (pending_fields.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FIELD_SIZE_SEL: dec_size_sel = val[1:0];
         CSR_ENCODING_MODE:  dec_enc = val[1:0];
         CSR_SIGNED_RESULT:  dec_sgn = val[0];
         default: ;
      endcase
   endtask

   task automatic send_random_field();
      int          size, limit, n, shape;
      logic [7:0]  b;
      logic        last;
      size  = 1 << dec_size_sel;
      shape = $urandom_range(99);
      if (shape < 8) begin
         n = $urandom_range(1, 4);
         repeat (n) send_byte(8'($urandom), ($urandom_range(3) == 0), 1'b0, '0);
         return;
      end
      if (dec_enc == ENC_VARINT && size > 1) begin
         limit = (size == 2) ? VARINT_LIMIT_16 : (size == 4) ? VARINT_LIMIT_32
                                                             : VARINT_LIMIT_64;
         if (limit > MAX_VARINT_BYTES)
            limit = MAX_VARINT_BYTES;
         // Well-formed, then over-long, then cut short by the buffer end.
         if (shape < 75)
            n = $urandom_range(1, limit);
         else if (shape < 88)
            n = limit;
         else
            n = $urandom_range(1, limit - 1);
         for (int k = 0; k < n; k++) begin
            b = 8'($urandom);
            if (k == n - 1 && $urandom_range(3) == 0)
               b[6:0] = 7'($urandom_range(3));
            b[7] = (shape >= 75) || (k != n - 1);
            last = (k == n - 1) ? ((shape >= 88) || $urandom_range(1))
                                : ($urandom_range(31) == 0);
            send_byte(b, last, 1'b0, '0);
         end
      end else begin
         n = (shape >= 88 && size > 1) ? $urandom_range(1, size - 1) : size;
         for (int k = 0; k < n; k++) begin
            last = (k == n - 1) ? ((shape >= 88) || $urandom_range(1))
                                : ($urandom_range(31) == 0);
            send_byte(8'($urandom), last, 1'b0, '0);
         end
      end
   endtask

   task automatic run_segment();
      int nfields;
      if ($urandom_range(99) < 70)
         write_csr(CSR_FIELD_SIZE_SEL, 8'($urandom_range(3)));
      if ($urandom_range(99) < 70)
         write_csr(CSR_ENCODING_MODE, ($urandom_range(9) == 0) ? 8'(ENC_AS_LITTLE)
                                                              : 8'($urandom_range(2)));
      if ($urandom_range(99) < 50)
         write_csr(CSR_SIGNED_RESULT, 8'($urandom_range(1)));
      nfields = $urandom_range(4, 24);
      repeat (nfields) send_random_field();
      // Sometimes leave a field open so the next settings apply to its tail.
      if ($urandom_range(4) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom) | CONT_BIT, 1'b0, 1'b0, '0);
   endtask

   function automatic dir_row_type csr_row(input logic [1:0] idx, input logic [7:0] val);
      dir_row_type row;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.data  = val;
      row.last  = 1'b0;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic dir_row_type byte_row(input logic [7:0] b, input logic last);
      dir_row_type row;
      row.kind  = ROW_BYTE;
      row.index = '0;
      row.data  = b;
      row.last  = last;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic dir_row_type byte_chk(input logic [7:0] b, input logic last,
                                            input logic [63:0] value, input status_type st,
                                            input logic [3:0] nbytes);
      dir_row_type row;
      row = byte_row(b, last);
      row.typed       = 1'b1;
      row.want.value  = value;
      row.want.status = st;
      row.want.nbytes = nbytes;
      return row;
   endfunction

   initial begin
      dir_row_type rows[$];
      int wait_cycles;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 4-byte little endian, unsigned.
      rows.push_back(byte_row(8'h78, 1'b0));
      rows.push_back(byte_row(8'h56, 1'b0));
      rows.push_back(byte_row(8'h34, 1'b0));
      rows.push_back(byte_chk(8'h12, 1'b0, 64'h1234_5678, STATUS_OK, 4'd2 << 1));
      rows.push_back(byte_row(8'hff, 1'b0));
      rows.push_back(byte_chk(8'hff, 1'b1, 64'd0, STATUS_TRUNC, 4'd2));
      rows.push_back(csr_row(CSR_FIELD_SIZE_SEL, 8'(SIZE_1B)));
      rows.push_back(byte_chk(8'h00, 1'b0, 64'd0, STATUS_OK, 4'd1));
      rows.push_back(byte_chk(8'hff, 1'b1, 64'hff, STATUS_OK, 4'd1));
      // Varint mode does not apply to single-byte fields.
      rows.push_back(csr_row(CSR_SIGNED_RESULT, 8'd1));
      rows.push_back(csr_row(CSR_ENCODING_MODE, 8'(ENC_VARINT)));
      rows.push_back(byte_chk(8'h80, 1'b0, 64'hffff_ffff_ffff_ff80, STATUS_OK, 4'd1));
      rows.push_back(csr_row(CSR_FIELD_SIZE_SEL, 8'(SIZE_2B)));
      rows.push_back(byte_chk(8'h01, 1'b0, '1, STATUS_OK, 4'd1));
      // Over-long varint wins over the buffer end on the same byte.
      rows.push_back(byte_row(8'hff, 1'b0));
      rows.push_back(byte_row(8'hff, 1'b0));
      rows.push_back(byte_chk(8'hff, 1'b1, 64'd0, STATUS_OVERFLOW, 4'd3));
      rows.push_back(byte_chk(8'h80, 1'b1, 64'd0, STATUS_TRUNC, 4'd1));
      rows.push_back(csr_row(CSR_ENCODING_MODE, 8'(ENC_BIG)));
      rows.push_back(byte_row(8'h80, 1'b0));
      rows.push_back(byte_chk(8'h01, 1'b0, 64'hffff_ffff_ffff_8001, STATUS_OK, 4'd2));
      rows.push_back(csr_row(CSR_ENCODING_MODE, 8'(ENC_AS_LITTLE)));
      rows.push_back(byte_row(8'h34, 1'b0));
      rows.push_back(byte_chk(8'h12, 1'b0, 64'h1234, STATUS_OK, 4'd2));
      rows.push_back(csr_row(CSR_FIELD_SIZE_SEL, 8'(SIZE_4B)));
      rows.push_back(csr_row(CSR_ENCODING_MODE, 8'(ENC_VARINT)));
      rows.push_back(byte_row(8'hff, 1'b0));
      rows.push_back(byte_row(8'hff, 1'b0));
      rows.push_back(byte_row(8'hff, 1'b0));
      rows.push_back(byte_row(8'hff, 1'b0));
      rows.push_back(byte_row(8'h0f, 1'b0));
      // A size change in the middle of a field makes its next byte complete it.
      rows.push_back(csr_row(CSR_ENCODING_MODE, 8'(ENC_LITTLE)));
      rows.push_back(csr_row(CSR_SIGNED_RESULT, 8'd0));
      rows.push_back(byte_row(8'haa, 1'b0));
      rows.push_back(csr_row(CSR_FIELD_SIZE_SEL, 8'(SIZE_1B)));
      rows.push_back(byte_row(8'h55, 1'b0));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR)
            write_csr(rows[i].index, rows[i].data);
         else
            send_byte(rows[i].data, rows[i].last, rows[i].typed, rows[i].want);
      end

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 64;
            recv_idle_pct = 17;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // Single-byte words each give a result, so the long hold-off
            // fills the byte queue and stalls the input.
            write_csr(CSR_FIELD_SIZE_SEL, 8'(SIZE_1B));
            stall_req = 1;
            repeat (40) send_byte(8'($urandom), 1'($urandom), 1'b0, '0);
         end
         while (items_sent < (ph + 1) * ITEM_TARGET / 3)
            run_segment();
      end

      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (pending_fields.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_fields.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
